// ===== rtl/kelt_pkg.sv =====
// ----------------------------------------------------------------------------
// kelt_pkg
// Shared constants and types for the keypad event list tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kelt_pkg;

	localparam int LIST_SIZE = 10;
	localparam int IDX_W     = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;

	// key states
	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_PRESSED  = 2'd1;
	localparam logic [1:0] ST_HOLD     = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	// encoder byte layout
	localparam logic [7:0] EMPTY_BYTE = 8'h3f;
	localparam int         REL_BIT    = 6;
	localparam int         MORE_BIT   = 7;

	// stream widths
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 16;

	// configuration port
	localparam int          CFG_ADDR_W    = 3;
	localparam int          CFG_DATA_W    = 32;
	localparam logic [0:0]  REG_HOLD_TIME = 1'b0;
	localparam logic [15:0] HOLD_RESET    = 16'd500;

	typedef struct packed {
		logic [1:0] state;
		logic       moved;
		logic       load_start;
	} adv_res_t;

endpackage

`default_nettype wire

// ===== rtl/kelt_adv.sv =====
// ----------------------------------------------------------------------------
// kelt_adv
// Shared slot advance unit: next state of one entry, with the hold timer test.
// ----------------------------------------------------------------------------
`default_nettype none

module kelt_adv (
	input  logic [1:0]        cur_state,
	input  logic              closed,
	input  logic [31:0]       now_ms,
	input  logic [31:0]       hold_start_ms,
	input  logic [15:0]       hold_time_ms,
	output kelt_pkg::adv_res_t res
);
	import kelt_pkg::*;

	logic [31:0] elapsed;
	logic        expired;

	assign elapsed = now_ms - hold_start_ms;
	assign expired = elapsed > {16'b0, hold_time_ms};

	always_comb begin
		res = '{state: cur_state, moved: 1'b0, load_start: 1'b0};
		unique case (cur_state)
			ST_IDLE: begin
				if (closed) begin
					res = '{state: ST_PRESSED, moved: 1'b1, load_start: 1'b1};
				end
			end
			ST_PRESSED: begin
				if (expired) begin
					res = '{state: ST_HOLD, moved: 1'b1, load_start: 1'b0};
				end else if (!closed) begin
					res = '{state: ST_RELEASED, moved: 1'b1, load_start: 1'b0};
				end
			end
			ST_HOLD: begin
				if (!closed) begin
					res = '{state: ST_RELEASED, moved: 1'b1, load_start: 1'b0};
				end
			end
			default: begin
				res = '{state: ST_IDLE, moved: 1'b1, load_start: 1'b0};
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/kelt_cfg.sv =====
// ----------------------------------------------------------------------------
// kelt_cfg
// Register port: holds the hold time register.
// ----------------------------------------------------------------------------
`default_nettype none

module kelt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [kelt_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [kelt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [kelt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [15:0]                     hold_time_ms
);
	import kelt_pkg::*;

	logic [15:0] hold_time_q;
	logic        sel_hold;

	assign sel_hold = paddr[CFG_ADDR_W-1:2] == REG_HOLD_TIME;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= HOLD_RESET;
		end else if (psel && penable && pwrite && pready && sel_hold) begin
			hold_time_q <= pwdata[15:0];
		end
	end

	assign prdata       = sel_hold ? {{(CFG_DATA_W-16){1'b0}}, hold_time_q} : '0;
	assign hold_time_ms = hold_time_q;

endmodule

`default_nettype wire

// ===== rtl/keypad_event_list_tracker_core.sv =====
// ----------------------------------------------------------------------------
// keypad_event_list_tracker_core
// Tracks pressed, held and released keys from key-encoder FIFO bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         one FIFO byte with its timestamp and first-of-read flag
//  m_axis    out        one key report per byte; tlast marks the end of a read
//  apb       in/out     hold time register at byte address 0
//
//  Each item is accepted, then scanned slot by slot through the shared
//  advance unit, then applied.
//  s_axis_tready is high only while the sequencer is idle.
//  The apply step waits while an earlier result still sits in the output
//  register; the target slot is written only when the result is loaded.
//  Reset empties the slot list, zeroes the hold start time and sets the
//  hold time to 500.
//
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_event_list_tracker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// fifo_byte [7:0], now_ms [39:8]
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [kelt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// new_read [0]
	input  logic [kelt_pkg::IN_USER_W-1:0]  s_axis_tuser,
	// key_code [5:0], key_state [7:6], state_changed [8], tracked [9],
	// dropped_full [10], any_activity [11], zero [15:12]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [kelt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// read_done
	output logic                            m_axis_tlast,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [kelt_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [kelt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [kelt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import kelt_pkg::*;

	// sequencer states
	localparam logic [1:0] SQ_IDLE  = 2'd0;
	localparam logic [1:0] SQ_SCAN  = 2'd1;
	localparam logic [1:0] SQ_APPLY = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_SIZE - 1);

	logic [15:0] hold_time_ms;

	kelt_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.hold_time_ms (hold_time_ms)
	);

	// slot list
	logic       slot_valid_q   [LIST_SIZE];
	logic [5:0] slot_code_q    [LIST_SIZE];
	logic [1:0] slot_state_q   [LIST_SIZE];
	logic       slot_changed_q [LIST_SIZE];
	logic [31:0] hold_start_q;

	// item being worked on
	logic [1:0]       seq_q;
	logic [7:0]       byte_q;
	logic [31:0]      now_q;
	logic             new_read_q;
	logic [IDX_W-1:0] idx_q;
	logic             found_q;
	logic [IDX_W-1:0] k_q;
	logic [1:0]       k_state_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_q;
	logic             act_q;

	// output register
	logic       out_valid_q;
	logic [5:0] out_code_q;
	logic [1:0] out_state_q;
	logic       out_chg_q;
	logic       out_trk_q;
	logic       out_drop_q;
	logic       out_done_q;
	logic       out_act_q;

	logic             in_acc;
	logic             is_empty;
	logic [5:0]       kc;
	logic             closed;
	logic             cur_valid;
	logic [5:0]       cur_code;
	logic [1:0]       cur_state;
	logic             cur_chg;
	logic             in_scan;
	logic             purge;
	logic             live;
	logic             sweep_hit;
	logic             match;
	logic             alloc;
	logic             target;
	logic             drop;
	logic [IDX_W-1:0] tgt_idx;
	logic [1:0]       tgt_state;
	logic             apply_go;
	logic             done;
	logic [1:0]       adv_state_in;
	logic             adv_closed_in;
	adv_res_t         adv;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = seq_q == SQ_IDLE;

	assign is_empty = byte_q == EMPTY_BYTE;
	assign kc       = byte_q[5:0];
	assign closed   = !byte_q[REL_BIT];
	assign done     = is_empty || !byte_q[MORE_BIT];

	// scan: look at one slot per cycle
	assign in_scan   = seq_q == SQ_SCAN;
	assign cur_valid = slot_valid_q[idx_q];
	assign cur_code  = slot_code_q[idx_q];
	assign cur_state = slot_state_q[idx_q];
	assign cur_chg   = slot_changed_q[idx_q];
	assign purge     = new_read_q && cur_valid && cur_state == ST_IDLE;
	assign live      = cur_valid && !purge;
	assign sweep_hit = is_empty && live && cur_state != ST_PRESSED;
	assign match     = !is_empty && live && cur_code == kc && !found_q;

	// apply: act on the matched slot, or take the lowest free one
	assign alloc     = !found_q && closed && free_found_q;
	assign target    = !is_empty && (found_q || alloc);
	assign drop      = !is_empty && !found_q && closed && !free_found_q;
	assign tgt_idx   = found_q ? k_q : free_q;
	assign tgt_state = found_q ? k_state_q : ST_IDLE;
	assign apply_go  = (seq_q == SQ_APPLY) && (!out_valid_q || m_axis_tready);

	// the one advance unit serves the sweep and the apply step
	assign adv_state_in  = in_scan ? cur_state : tgt_state;
	assign adv_closed_in = in_scan ? 1'b0 : closed;

	kelt_adv u_adv (
		.cur_state     (adv_state_in),
		.closed        (adv_closed_in),
		.now_ms        (now_q),
		.hold_start_ms (hold_start_q),
		.hold_time_ms  (hold_time_ms),
		.res           (adv)
	);

	// sequencer and scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SQ_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			act_q        <= 1'b0;
		end else begin
			unique case (seq_q)
				SQ_IDLE: begin
					if (in_acc) begin
						seq_q        <= SQ_SCAN;
						idx_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						act_q        <= 1'b0;
					end
				end
				SQ_SCAN: begin
					if (sweep_hit) begin
						act_q <= 1'b1;
					end
					// changed flags of every slot but the one acted on
					if (!is_empty && live && !match && cur_chg) begin
						act_q <= 1'b1;
					end
					if (match) begin
						found_q <= 1'b1;
					end
					if (!live && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						seq_q <= SQ_APPLY;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				SQ_APPLY: begin
					if (apply_go) begin
						seq_q <= SQ_IDLE;
					end
				end
				default: begin
					seq_q <= SQ_IDLE;
				end
			endcase
		end
	end

	// item payload and scan captures
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_q     <= s_axis_tdata[7:0];
			now_q      <= s_axis_tdata[39:8];
			new_read_q <= s_axis_tuser[0];
		end
		if (in_scan && match) begin
			k_q       <= idx_q;
			k_state_q <= cur_state;
		end
		if (in_scan && !live && !free_found_q) begin
			free_q <= idx_q;
		end
	end

	// slot list updates: purge and sweep during scan, the target on apply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIST_SIZE; i++) begin
				slot_valid_q[i]   <= 1'b0;
				slot_state_q[i]   <= ST_IDLE;
				slot_changed_q[i] <= 1'b0;
			end
			hold_start_q <= '0;
		end else begin
			if (in_scan && purge) begin
				slot_valid_q[idx_q]   <= 1'b0;
				slot_changed_q[idx_q] <= 1'b0;
			end
			if (in_scan && sweep_hit) begin
				slot_state_q[idx_q]   <= adv.state;
				slot_changed_q[idx_q] <= adv.moved;
			end
			if (apply_go && target) begin
				if (alloc) begin
					slot_valid_q[tgt_idx] <= 1'b1;
				end
				slot_state_q[tgt_idx]   <= adv.state;
				slot_changed_q[tgt_idx] <= adv.moved;
				if (adv.load_start) begin
					hold_start_q <= now_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go && target && alloc) begin
			slot_code_q[free_q] <= kc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			out_code_q  <= is_empty ? 6'd0 : kc;
			out_state_q <= target ? adv.state : ST_IDLE;
			out_chg_q   <= target && adv.moved;
			out_trk_q   <= target;
			out_drop_q  <= drop;
			out_done_q  <= done;
			out_act_q   <= is_empty ? act_q : (done && (act_q || (target && adv.moved)));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_done_q;
	assign m_axis_tdata  = {4'b0, out_act_q, out_drop_q, out_trk_q, out_chg_q,
		out_state_q, out_code_q};

endmodule

`default_nettype wire
